// File: rtl/tcpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpl_pkg
// Shared widths, codes and controller/datapath interface types for the
// triangle cell point locator.
// ----------------------------------------------------------------------------
package tcpl_pkg;

	localparam int CoordW    = 32;
	localparam int NodeDepth = 256;
	localparam int CellDepth = 512;
	localparam int NodeAw    = $clog2(NodeDepth);
	localparam int CellAw    = $clog2(CellDepth);
	localparam int VertW     = 8;
	localparam int CntW      = 10;
	localparam int NodeW     = 3 * CoordW;
	localparam int CellW     = 3 * VertW;
	// operand width covers 3p - (a+b+c) and 2p - (a+b)
	localparam int OpW       = CoordW + 3;
	localparam int ProdW     = 2 * OpW;

	localparam logic [1:0] OP_WR_NODE = 2'd0;
	localparam logic [1:0] OP_WR_CELL = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] ST_INSIDE  = 2'd0;
	localparam logic [1:0] ST_NEAREST = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LD_VERT,
		DP_LD_A,
		DP_LD_B,
		DP_LD_C,
		DP_EDGE_OPND,
		DP_MUL1,
		DP_MUL2,
		DP_NEAR_OPND,
		DP_NEAR_MUL,
		DP_NEAR_ACC,
		DP_NEAR_CMP,
		DP_RES_INSIDE,
		DP_RES_NEAR,
		DP_RES_EMPTY
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [1:0]        sel;       // edge or axis
		logic [1:0]        node_sel;  // vertex addressed in node memory
		logic [CellAw-1:0] cell_idx;
		logic              first;
		logic              wr_node;
		logic              wr_cell;
		logic              ld_point;
	} dp_cmd_t;

	typedef struct packed {
		logic edge_out;
	} dp_stat_t;

endpackage

// File: rtl/triangle_cell_point_locator.sv
`timescale 1ns / 1ps
// Node and cell writes are done in the accepting cycle; a query with no cells gives its
// result strobe in the cycle after start. Otherwise the inside pass fetches each cell's
// vertices and nodes from memory, then tests its edges (one shared multiplier, two products
// per edge), and a miss adds a nearest centroid pass over all cells before the result.
// One item at a time: busy stays high until the done strobe cycle; results cannot stall.
// Reset clears the cell count and control; memory contents are undefined until written.
// ----------------------------------------------------------------------------
// triangle_cell_point_locator
// Locates a query point in a triangle mesh held in on-chip node and cell memories.
// ----------------------------------------------------------------------------
module triangle_cell_point_locator
	import tcpl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               operation,
	input  logic [8:0]               slot,
	input  logic signed [CoordW-1:0] coord_x,
	input  logic signed [CoordW-1:0] coord_y,
	input  logic signed [CoordW-1:0] coord_z,
	input  logic [VertW-1:0]         vertex_a,
	input  logic [VertW-1:0]         vertex_b,
	input  logic [VertW-1:0]         vertex_c,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CntW-1:0]          cfg_data,
	output logic                     done,
	output logic [1:0]               status,
	output logic [CellAw-1:0]        cell_found,
	output logic [VertW-1:0]         node_first,
	output logic [VertW-1:0]         node_second,
	output logic [VertW-1:0]         node_third
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// query sequencer
	tcpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.operation (operation),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	// memories and arithmetic
	tcpl_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.slot        (slot),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.vertex_c    (vertex_c),
		.status      (status),
		.cell_found  (cell_found),
		.node_first  (node_first),
		.node_second (node_second),
		.node_third  (node_third)
	);

endmodule

// File: rtl/tcpl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpl_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tcpl_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tcpl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpl_datapath
// Node and cell memories, vertex registers, shared multiplier, edge test,
// centroid distance accumulation and result registers.
// ----------------------------------------------------------------------------
module tcpl_datapath
	import tcpl_pkg::*;
(
	input  logic                    clk,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	input  logic [8:0]              slot,
	input  logic signed [CoordW-1:0] coord_x,
	input  logic signed [CoordW-1:0] coord_y,
	input  logic signed [CoordW-1:0] coord_z,
	input  logic [VertW-1:0]        vertex_a,
	input  logic [VertW-1:0]        vertex_b,
	input  logic [VertW-1:0]        vertex_c,
	output logic [1:0]              status,
	output logic [CellAw-1:0]       cell_found,
	output logic [VertW-1:0]        node_first,
	output logic [VertW-1:0]        node_second,
	output logic [VertW-1:0]        node_third
);

	function automatic logic signed [OpW-1:0] sx(input logic [CoordW-1:0] v);
		sx = {{(OpW-CoordW){v[CoordW-1]}}, v};
	endfunction

	logic [NodeW-1:0] node_rdata;
	logic [CellW-1:0] cell_rdata;
	logic [NodeAw-1:0] node_raddr;

	logic [2:0][CoordW-1:0]        pt_q;     // query point by axis
	logic [2:0][2:0][CoordW-1:0]   nd_q;     // [vertex][axis]
	logic [2:0][VertW-1:0]         vt_q;     // current cell vertices
	logic [2:0][VertW-1:0]         best_vt_q;
	logic [CellAw-1:0]             best_idx_q;
	logic [ProdW-1:0]              best_q;
	logic [ProdW-1:0]              acc_q;
	logic signed [OpW-1:0]         m1a_q, m1b_q, m2a_q, m2b_q;
	logic signed [ProdW-1:0]       prod_q, prod1_q;

	logic [1:0]                    nxt;
	logic signed [OpW-1:0]         ex, ey, dx, dy, diff;
	logic signed [OpW-1:0]         mul_a, mul_b;
	logic signed [ProdW-1:0]       mul_full;

	// memories
	tcpl_ram #(.Width(NodeW), .Depth(NodeDepth)) u_node_ram (
		.clk   (clk),
		.we    (cmd.wr_node && !slot[8]),
		.waddr (slot[NodeAw-1:0]),
		.wdata ({coord_z, coord_y, coord_x}),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	tcpl_ram #(.Width(CellW), .Depth(CellDepth)) u_cell_ram (
		.clk   (clk),
		.we    (cmd.wr_cell),
		.waddr (slot[CellAw-1:0]),
		.wdata ({vertex_c, vertex_b, vertex_a}),
		.raddr (cmd.cell_idx),
		.rdata (cell_rdata)
	);

	assign node_raddr = vt_q[cmd.node_sel];

	// edge operands: edge sel runs from vertex sel to the next one
	always_comb begin
		nxt  = (cmd.sel == 2'd2) ? 2'd0 : cmd.sel + 2'd1;
		ex   = sx(nd_q[nxt][0]) - sx(nd_q[cmd.sel][0]);
		ey   = sx(nd_q[nxt][1]) - sx(nd_q[cmd.sel][1]);
		dx   = (sx(pt_q[0]) <<< 1) - sx(nd_q[cmd.sel][0]) - sx(nd_q[nxt][0]);
		dy   = (sx(pt_q[1]) <<< 1) - sx(nd_q[cmd.sel][1]) - sx(nd_q[nxt][1]);
		diff = sx(pt_q[cmd.sel]) + (sx(pt_q[cmd.sel]) <<< 1)
		       - sx(nd_q[0][cmd.sel]) - sx(nd_q[1][cmd.sel]) - sx(nd_q[2][cmd.sel]);
	end

	// shared multiplier
	always_comb begin
		mul_a    = (cmd.op == DP_MUL2) ? m2a_q : m1a_q;
		mul_b    = (cmd.op == DP_MUL2) ? m2b_q : m1b_q;
		mul_full = ProdW'(mul_a) * ProdW'(mul_b);
	end

	assign stat.edge_out = (prod1_q > prod_q);

	// query point capture
	always_ff @(posedge clk) begin
		if (cmd.ld_point) begin
			pt_q <= {coord_z, coord_y, coord_x};
		end
	end

	// sequenced datapath operations
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LD_VERT: vt_q <= cell_rdata;
			DP_LD_A: nd_q[0] <= node_rdata;
			DP_LD_B: nd_q[1] <= node_rdata;
			DP_LD_C: nd_q[2] <= node_rdata;
			DP_EDGE_OPND: begin
				m1a_q <= ey;
				m1b_q <= dx;
				m2a_q <= ex;
				m2b_q <= dy;
			end
			DP_MUL1: prod_q <= mul_full;
			DP_MUL2: begin
				prod1_q <= prod_q;
				prod_q  <= mul_full;
			end
			DP_NEAR_OPND: begin
				m1a_q <= diff;
				m1b_q <= diff;
			end
			DP_NEAR_MUL: prod_q <= mul_full;
			DP_NEAR_ACC: begin
				if (cmd.sel == 2'd0) begin
					acc_q <= $unsigned(prod_q);
				end else begin
					acc_q <= acc_q + $unsigned(prod_q);
				end
			end
			DP_NEAR_CMP: begin
				if (cmd.first || (acc_q < best_q)) begin
					best_q     <= acc_q;
					best_idx_q <= cmd.cell_idx;
					best_vt_q  <= vt_q;
				end
			end
			DP_RES_INSIDE: begin
				status      <= ST_INSIDE;
				cell_found  <= cmd.cell_idx;
				node_first  <= vt_q[0];
				node_second <= vt_q[1];
				node_third  <= vt_q[2];
			end
			DP_RES_NEAR: begin
				status      <= ST_NEAREST;
				cell_found  <= best_idx_q;
				node_first  <= best_vt_q[0];
				node_second <= best_vt_q[1];
				node_third  <= best_vt_q[2];
			end
			DP_RES_EMPTY: begin
				status      <= ST_EMPTY;
				cell_found  <= '0;
				node_first  <= '0;
				node_second <= '0;
				node_third  <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/tcpl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpl_ctrl
// Query sequencer: inside pass over cells, then on a miss a nearest centroid pass,
// and the cell count register.
// ----------------------------------------------------------------------------
module tcpl_ctrl
	import tcpl_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	input  logic [1:0]      operation,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CntW-1:0] cfg_data,
	output dp_cmd_t         cmd,
	input  dp_stat_t        stat
);

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_CELL_RD = 17'h00002,
		S_VERT    = 17'h00004,
		S_NODE_A  = 17'h00008,
		S_NODE_B  = 17'h00010,
		S_NODE_C  = 17'h00020,
		S_NODE_W  = 17'h00040,
		S_E_OPND  = 17'h00080,
		S_E_MUL1  = 17'h00100,
		S_E_MUL2  = 17'h00200,
		S_E_CMP   = 17'h00400,
		S_N_OPND  = 17'h00800,
		S_N_MUL   = 17'h01000,
		S_N_ACC   = 17'h02000,
		S_N_CMP   = 17'h04000,
		S_N_FIN   = 17'h08000,
		S_DONE    = 17'h10000
	} state_t;

	state_t            state_q, state_d;
	logic [CntW-1:0]   count_q;
	logic [CellAw-1:0] idx_q, idx_d;
	logic [1:0]        sel_q, sel_d;
	logic              near_q, near_d;
	logic [CntW-1:0]   n_cells;
	logic              last;
	logic              accept;

	assign n_cells   = (count_q > CntW'(CellDepth)) ? CntW'(CellDepth) : count_q;
	assign last      = ({1'b0, idx_q} + CntW'(1)) == n_cells;
	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign cfg_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		sel_d        = sel_q;
		near_d       = near_q;
		cmd          = '0;
		cmd.op       = DP_NOP;
		cmd.sel      = sel_q;
		cmd.cell_idx = idx_q;
		cmd.first    = (idx_q == '0);
		unique case (state_q)
			S_IDLE: begin
				cmd.wr_node  = accept && (operation == OP_WR_NODE);
				cmd.wr_cell  = accept && (operation == OP_WR_CELL);
				cmd.ld_point = accept && (operation == OP_QUERY);
				if (accept && (operation == OP_QUERY)) begin
					if (n_cells == '0) begin
						cmd.op  = DP_RES_EMPTY;
						state_d = S_DONE;
					end else begin
						idx_d   = '0;
						near_d  = 1'b0;
						state_d = S_CELL_RD;
					end
				end
			end
			S_CELL_RD: state_d = S_VERT;
			S_VERT: begin
				cmd.op  = DP_LD_VERT;
				state_d = S_NODE_A;
			end
			S_NODE_A: begin
				cmd.node_sel = 2'd0;
				state_d      = S_NODE_B;
			end
			S_NODE_B: begin
				cmd.node_sel = 2'd1;
				cmd.op       = DP_LD_A;
				state_d      = S_NODE_C;
			end
			S_NODE_C: begin
				cmd.node_sel = 2'd2;
				cmd.op       = DP_LD_B;
				state_d      = S_NODE_W;
			end
			S_NODE_W: begin
				cmd.op  = DP_LD_C;
				sel_d   = 2'd0;
				state_d = near_q ? S_N_OPND : S_E_OPND;
			end
			S_E_OPND: begin
				cmd.op  = DP_EDGE_OPND;
				state_d = S_E_MUL1;
			end
			S_E_MUL1: begin
				cmd.op  = DP_MUL1;
				state_d = S_E_MUL2;
			end
			S_E_MUL2: begin
				cmd.op  = DP_MUL2;
				state_d = S_E_CMP;
			end
			S_E_CMP: begin
				// outside this cell: next cell or start nearest pass
				if (stat.edge_out) begin
					state_d = S_CELL_RD;
					if (last) begin
						idx_d  = '0;
						near_d = 1'b1;
					end else begin
						idx_d = idx_q + CellAw'(1);
					end
				end else if (sel_q == 2'd2) begin
					cmd.op  = DP_RES_INSIDE;
					state_d = S_DONE;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = S_E_OPND;
				end
			end
			S_N_OPND: begin
				cmd.op  = DP_NEAR_OPND;
				state_d = S_N_MUL;
			end
			S_N_MUL: begin
				cmd.op  = DP_NEAR_MUL;
				state_d = S_N_ACC;
			end
			S_N_ACC: begin
				cmd.op = DP_NEAR_ACC;
				if (sel_q == 2'd2) begin
					state_d = S_N_CMP;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = S_N_OPND;
				end
			end
			S_N_CMP: begin
				cmd.op = DP_NEAR_CMP;
				if (last) begin
					state_d = S_N_FIN;
				end else begin
					idx_d   = idx_q + CellAw'(1);
					state_d = S_CELL_RD;
				end
			end
			S_N_FIN: begin
				cmd.op  = DP_RES_NEAR;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			sel_q   <= '0;
			near_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sel_q   <= sel_d;
			near_q  <= near_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
		end
	end

endmodule
